// ===== sv/mbic_pkg.sv =====
// ----------------------------------------------------------------------------
// mbic_pkg
// shared types and constants of the per-core mailbox interrupt controller
// ----------------------------------------------------------------------------
package mbic_pkg;

  localparam int unsigned NUM_CORES_DEF     = 4;
  localparam int unsigned MBOX_PER_CORE_DEF = 4;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CORE_W  = 2;
  localparam int unsigned MBOX_W  = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LINES_W = 4;

  // bit positions in control and pending words
  localparam int unsigned MBOX_PEND_LSB   = 4;
  localparam int unsigned MBOX_CTRL_SHIFT = 4;
  localparam int unsigned TIMER_ROUTE_POS = 5;
  localparam int unsigned TIMER_PEND_POS  = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_MBOX_SET    = 3'd0,
    KIND_MBOX_CLEAR  = 3'd1,
    KIND_MBOX_READ   = 3'd2,
    KIND_MBOX_CTRL   = 3'd3,
    KIND_TIMER_CTRL  = 3'd4,
    KIND_PEND_READ   = 3'd5,
    KIND_TIMER_LINE  = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CORE_W-1:0] target_core;
    logic [MBOX_W-1:0] mailbox_index;
    logic [WORD_W-1:0] write_data;
    logic              timer_level;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_data;
    logic [LINES_W-1:0] fiq_lines;
  } rsp_t;

endpackage

// ===== sv/mbic_req_if.sv =====
// ----------------------------------------------------------------------------
// mbic_req_if
// access channel into the mailbox interrupt controller
// ----------------------------------------------------------------------------
interface mbic_req_if;
  import mbic_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CORE_W-1:0] target_core;
  logic [MBOX_W-1:0] mailbox_index;
  logic [WORD_W-1:0] write_data;
  logic              timer_level;

  modport source (
    output valid, kind, target_core, mailbox_index, write_data, timer_level,
    input  ready
  );

  modport sink (
    input  valid, kind, target_core, mailbox_index, write_data, timer_level,
    output ready
  );

endinterface

// ===== sv/mbic_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mbic_rsp_if
// result channel out of the mailbox interrupt controller
// ----------------------------------------------------------------------------
interface mbic_rsp_if;
  import mbic_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  read_data;
  logic [LINES_W-1:0] fiq_lines;

  modport source (
    output valid, read_data, fiq_lines,
    input  ready
  );

  modport sink (
    input  valid, read_data, fiq_lines,
    output ready
  );

endinterface

// ===== sv/mbic_regfile.sv =====
// ----------------------------------------------------------------------------
// mbic_regfile
// mailbox words, fiq enables, timer route and level, with the
// read-modify-write and fiq pending logic for one access
// ----------------------------------------------------------------------------
module mbic_regfile #(
  parameter int unsigned NUM_CORES     = mbic_pkg::NUM_CORES_DEF,
  parameter int unsigned MBOX_PER_CORE = mbic_pkg::MBOX_PER_CORE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  mbic_pkg::req_t req,
  output mbic_pkg::rsp_t rsp
);
  import mbic_pkg::*;

  localparam int unsigned SLOTS = NUM_CORES * MBOX_PER_CORE;

  logic [WORD_W-1:0]        words      [SLOTS];
  logic [SLOTS-1:0]         nz;
  logic [MBOX_PER_CORE-1:0] fiq_enable [NUM_CORES];
  logic [NUM_CORES-1:0]     route;
  logic [NUM_CORES-1:0]     level;

  logic [WORD_W-1:0]        words_next      [SLOTS];
  logic [SLOTS-1:0]         nz_next;
  logic [MBOX_PER_CORE-1:0] fiq_enable_next [NUM_CORES];
  logic [NUM_CORES-1:0]     route_next;
  logic [NUM_CORES-1:0]     level_next;

  logic is_set, is_clear, is_read, is_mctrl, is_tctrl, is_pread, is_tline;

  always_comb begin
    is_set   = 1'b0;
    is_clear = 1'b0;
    is_read  = 1'b0;
    is_mctrl = 1'b0;
    is_tctrl = 1'b0;
    is_pread = 1'b0;
    is_tline = 1'b0;
    unique case (req.kind)
      KIND_MBOX_SET:   is_set   = 1'b1;
      KIND_MBOX_CLEAR: is_clear = 1'b1;
      KIND_MBOX_READ:  is_read  = 1'b1;
      KIND_MBOX_CTRL:  is_mctrl = 1'b1;
      KIND_TIMER_CTRL: is_tctrl = 1'b1;
      KIND_PEND_READ:  is_pread = 1'b1;
      KIND_TIMER_LINE: is_tline = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    logic              core_hit;
    logic              slot_hit;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] pend_cur;
    logic [WORD_W-1:0] pend_nxt;
    logic [WORD_W-1:0] rd;
    logic [LINES_W-1:0] lines;

    rd    = '0;
    lines = '0;
    for (int c = 0; c < int'(NUM_CORES); c++) begin
      core_hit = (int'(req.target_core) == c);
      pend_cur = '0;
      pend_nxt = '0;

      fiq_enable_next[c] = (core_hit && is_mctrl) ?
                           req.write_data[MBOX_CTRL_SHIFT +: MBOX_PER_CORE] :
                           fiq_enable[c];
      route_next[c] = (core_hit && is_tctrl) ? req.write_data[TIMER_ROUTE_POS] : route[c];
      level_next[c] = (core_hit && is_tline) ? req.timer_level : level[c];

      for (int m = 0; m < int'(MBOX_PER_CORE); m++) begin
        slot_hit = core_hit && (int'(req.mailbox_index) == m);
        cur = nz[c*MBOX_PER_CORE + m] ? words[c*MBOX_PER_CORE + m] : '0;
        words_next[c*MBOX_PER_CORE + m] =
          (slot_hit && is_set)   ? (cur | req.write_data) :
          (slot_hit && is_clear) ? (cur & ~req.write_data) : cur;
        nz_next[c*MBOX_PER_CORE + m] = |words_next[c*MBOX_PER_CORE + m];
        if (slot_hit && is_read) begin
          rd = rd | cur;
        end
        pend_cur[MBOX_PEND_LSB + m] = fiq_enable[c][m] & nz[c*MBOX_PER_CORE + m];
        pend_nxt[MBOX_PEND_LSB + m] = fiq_enable_next[c][m] & nz_next[c*MBOX_PER_CORE + m];
      end

      pend_cur[TIMER_PEND_POS] = route[c] & level[c];
      pend_nxt[TIMER_PEND_POS] = route_next[c] & level_next[c];

      if (core_hit && is_pread) begin
        rd = rd | pend_cur;
      end
      if (c < int'(LINES_W)) begin
        lines[c] = |pend_nxt;
      end
    end

    rsp.read_data = rd;
    rsp.fiq_lines = lines;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz    <= '0;
      route <= '0;
      level <= '0;
      for (int c = 0; c < int'(NUM_CORES); c++) begin
        fiq_enable[c] <= '0;
      end
    end else if (en) begin
      nz    <= nz_next;
      route <= route_next;
      level <= level_next;
      for (int c = 0; c < int'(NUM_CORES); c++) begin
        fiq_enable[c] <= fiq_enable_next[c];
      end
    end
  end

  // word contents are qualified by nz, so they need no reset
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < int'(SLOTS); s++) begin
        words[s] <= words_next[s];
      end
    end
  end

endmodule

// ===== sv/mailbox_interrupt_controller_top.sv =====
// ----------------------------------------------------------------------------
// mailbox_interrupt_controller_top
// per-core mailbox fiq controller with registered access and result stages
// ----------------------------------------------------------------------------
// Each accepted item is one register access (mailbox set, clear or read,
// mailbox fiq enable write, timer route write, fiq pending read or timer
// line update) and yields exactly one result item carrying the read data
// and the four cores' fiq lines as they stand after the access. An item is
// captured in an input register, applied to the register file as one
// read-modify-write when it moves on to the output register, which holds
// its result; the block takes one item per cycle while the result side
// keeps up, and a result not yet taken stalls the item behind it. State
// comes out of reset as all zero with no clearing pass.
module mailbox_interrupt_controller_top #(
  parameter int unsigned NUM_CORES     = mbic_pkg::NUM_CORES_DEF,
  parameter int unsigned MBOX_PER_CORE = mbic_pkg::MBOX_PER_CORE_DEF
) (
  input logic       clk,
  input logic       rst,
  mbic_req_if.sink  req,
  mbic_rsp_if.source rsp
);
  import mbic_pkg::*;

  req_t req_q;
  logic req_valid;
  rsp_t rsp_comb;
  rsp_t rsp_q;
  logic rsp_valid;
  logic advance;

  assign advance   = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.kind          <= kind_t'(req.kind);
      req_q.target_core   <= req.target_core;
      req_q.mailbox_index <= req.mailbox_index;
      req_q.write_data    <= req.write_data;
      req_q.timer_level   <= req.timer_level;
    end
  end

  mbic_regfile #(
    .NUM_CORES     (NUM_CORES),
    .MBOX_PER_CORE (MBOX_PER_CORE)
  ) u_regfile (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .req (req_q),
    .rsp (rsp_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp_comb;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_q.read_data;
  assign rsp.fiq_lines = rsp_q.fiq_lines;

endmodule
